FILE: hdl/icsp_pkg.sv
// Shared types, constants and sequence tables for the serial programming master.
// Used by icsp_cfg, icsp_seq and icsp_serial_programming_master.
package icsp_pkg;

  // Width of the tick wait counter and of the timing registers.
  localparam int WAIT_BITS = 24;
  localparam int CFG_BITS  = 24;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PHASE_TICKS  = 2'd0;
  localparam logic [1:0] CFG_GAP_TICKS    = 2'd1;
  localparam logic [1:0] CFG_ERASE_TICKS  = 2'd2;
  localparam logic [1:0] CFG_BULK_TICKS   = 2'd3;

  // Action codes.
  localparam logic [3:0] ACT_NONE        = 4'd0;
  localparam logic [3:0] ACT_READ_PROG   = 4'd3;
  localparam logic [3:0] ACT_READ_DATA   = 4'd8;
  localparam logic [3:0] ACT_ERASE_PROG  = 4'd11;
  localparam logic [3:0] ACT_ERASE_DATA  = 4'd12;
  localparam logic [3:0] ACT_ERASE_PROT  = 4'd13;
  localparam logic [3:0] ACT_LOAD_CONFIG = 4'd1;
  localparam logic [3:0] ACT_LOAD_PROG   = 4'd2;
  localparam logic [3:0] ACT_INC_ADDR    = 4'd4;
  localparam logic [3:0] ACT_BEGIN_EP    = 4'd5;
  localparam logic [3:0] ACT_BEGIN_PROG  = 4'd6;
  localparam logic [3:0] ACT_LOAD_DATA   = 4'd7;
  localparam logic [3:0] ACT_BULK_SETUP1 = 4'd9;
  localparam logic [3:0] ACT_BULK_SETUP2 = 4'd10;

  // Target command codes.
  localparam logic [5:0] CMD_LOAD_CONFIG = 6'h00;
  localparam logic [5:0] CMD_LOAD_PROG   = 6'h02;
  localparam logic [5:0] CMD_READ_PROG   = 6'h04;
  localparam logic [5:0] CMD_INC_ADDR    = 6'h06;
  localparam logic [5:0] CMD_BEGIN_EP    = 6'h08;
  localparam logic [5:0] CMD_BEGIN_PROG  = 6'h18;
  localparam logic [5:0] CMD_LOAD_DATA   = 6'h03;
  localparam logic [5:0] CMD_READ_DATA   = 6'h05;
  localparam logic [5:0] CMD_BULK_SETUP1 = 6'h01;
  localparam logic [5:0] CMD_BULK_SETUP2 = 6'h07;

  localparam logic [13:0] WORD_MASK  = 14'h3FFF;
  localparam logic [4:0]  CMD_BITS   = 5'd6;
  localparam logic [4:0]  FRAME_BITS = 5'd16;
  localparam logic [4:0]  STEP_MAX   = 5'd31;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD_LEAD, PH_CMD_HI, PH_CMD_LO, PH_CMD_TAIL,
    PH_WR_HI, PH_WR_LO, PH_WR_TAIL, PH_RD_LEAD, PH_RD_REL,
    PH_RD_HI, PH_RD_LO, PH_RD_TAIL, PH_LONG_E, PH_LONG_B
  } phase_t;

  typedef enum logic [2:0] {
    K_END, K_CMD, K_WR, K_RD, K_WE, K_WB
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] cmd;
  } seq_entry_t;

  typedef struct packed {
    phase_t      phase;
    logic        load_shift;
    logic [15:0] shift;
  } enter_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] phase_ticks;
    logic [CFG_BITS-1:0] command_gap_ticks;
    logic [CFG_BITS-1:0] erase_cycle_ticks;
    logic [CFG_BITS-1:0] bulk_erase_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [13:0] write_value;
    logic        data_pin_in;
  } in_item_t;

  typedef struct packed {
    logic        clock_pin;
    logic        data_pin;
    logic        data_drive;
    logic        busy_res;
    logic        rejected;
    logic        read_valid;
    logic [13:0] read_value;
  } out_item_t;

  function automatic seq_entry_t mk(kind_t kind, logic [5:0] cmd);
    seq_entry_t e;
    e.kind = kind;
    e.cmd  = cmd;
    return e;
  endfunction

  // Step list of one operation; past the end every step reads as the end mark.
  function automatic seq_entry_t seq_entry(logic [3:0] op, logic [4:0] step);
    seq_entry_t e;
    logic [5:0] load_cmd;
    e = mk(K_END, 6'h00);
    load_cmd = (op == ACT_ERASE_DATA) ? CMD_LOAD_DATA : CMD_LOAD_PROG;
    case (op)
      ACT_LOAD_CONFIG: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_LOAD_CONFIG);
        else if (step == 5'd1) e = mk(K_WR, 6'h00);
      end
      ACT_LOAD_PROG: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_LOAD_PROG);
        else if (step == 5'd1) e = mk(K_WR, 6'h00);
      end
      ACT_READ_PROG: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_READ_PROG);
        else if (step == 5'd1) e = mk(K_RD, 6'h00);
      end
      ACT_INC_ADDR: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_INC_ADDR);
      end
      ACT_BEGIN_EP: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_BEGIN_EP);
        else if (step == 5'd1) e = mk(K_WE, 6'h00);
      end
      ACT_BEGIN_PROG: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_BEGIN_PROG);
      end
      ACT_LOAD_DATA: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_LOAD_DATA);
        else if (step == 5'd1) e = mk(K_WR, 6'h00);
      end
      ACT_READ_DATA: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_READ_DATA);
        else if (step == 5'd1) e = mk(K_RD, 6'h00);
      end
      ACT_BULK_SETUP1: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_BULK_SETUP1);
      end
      ACT_BULK_SETUP2: begin
        if (step == 5'd0) e = mk(K_CMD, CMD_BULK_SETUP2);
      end
      ACT_ERASE_PROG, ACT_ERASE_DATA: begin
        case (step)
          5'd0: e = mk(K_CMD, load_cmd);
          5'd1: e = mk(K_WR, 6'h00);
          5'd2: e = mk(K_CMD, CMD_BULK_SETUP1);
          5'd3: e = mk(K_CMD, CMD_BULK_SETUP2);
          5'd4: e = mk(K_CMD, CMD_BEGIN_EP);
          5'd5: e = mk(K_WE, 6'h00);
          5'd6: e = mk(K_WB, 6'h00);
          5'd7: e = mk(K_CMD, CMD_BULK_SETUP1);
          5'd8: e = mk(K_CMD, CMD_BULK_SETUP2);
          default: e = mk(K_END, 6'h00);
        endcase
      end
      ACT_ERASE_PROT: begin
        case (step)
          5'd0: e = mk(K_CMD, CMD_LOAD_CONFIG);
          5'd1: e = mk(K_WR, 6'h00);
          5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8: e = mk(K_CMD, CMD_INC_ADDR);
          5'd9: e = mk(K_CMD, CMD_BULK_SETUP1);
          5'd10: e = mk(K_CMD, CMD_BULK_SETUP2);
          5'd11: e = mk(K_CMD, CMD_BEGIN_EP);
          5'd12: e = mk(K_WE, 6'h00);
          5'd13: e = mk(K_WB, 6'h00);
          5'd14: e = mk(K_CMD, CMD_BULK_SETUP1);
          5'd15: e = mk(K_CMD, CMD_BULK_SETUP2);
          default: e = mk(K_END, 6'h00);
        endcase
      end
      default: e = mk(K_END, 6'h00);
    endcase
    return e;
  endfunction

  // Phase and shift contents for the first segment of a step.
  function automatic enter_t enter_step(logic [3:0] op, logic [4:0] step,
                                        logic [13:0] held);
    enter_t r;
    seq_entry_t e;
    e = seq_entry(op, step);
    r.load_shift = 1'b0;
    r.shift      = 16'h0000;
    case (e.kind)
      K_CMD: begin
        r.phase      = PH_CMD_LEAD;
        r.load_shift = 1'b1;
        r.shift      = {10'h000, e.cmd};
      end
      K_WR: begin
        r.phase      = PH_WR_HI;
        r.load_shift = 1'b1;
        r.shift      = {1'b0, held & WORD_MASK, 1'b0};
      end
      K_RD:    r.phase = PH_RD_LEAD;
      K_WE:    r.phase = PH_LONG_E;
      K_WB:    r.phase = PH_LONG_B;
      default: r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  // A zero register still waits one tick.
  function automatic logic [WAIT_BITS-1:0] wait_len(logic [CFG_BITS-1:0] value);
    logic [WAIT_BITS-1:0] r;
    r = value;
    if (value == '0) r = WAIT_BITS'(1);
    return r;
  endfunction

endpackage

FILE: hdl/icsp_cfg.sv
// Timing configuration registers of the serial programming master.
// Depends on icsp_pkg for the register indexes and the register struct.
module icsp_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [icsp_pkg::CFG_BITS-1:0] wr_data,
  output icsp_pkg::cfg_regs_t   regs
);
  import icsp_pkg::*;

  // Register file with reset defaults; a write lands on the indexed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.phase_ticks       <= CFG_BITS'(10);
      regs.command_gap_ticks <= CFG_BITS'(100);
      regs.erase_cycle_ticks <= CFG_BITS'(400000);
      regs.bulk_erase_ticks  <= CFG_BITS'(1000000);
    end else if (wr_en) begin
      case (wr_index)
        CFG_PHASE_TICKS: regs.phase_ticks       <= wr_data;
        CFG_GAP_TICKS:   regs.command_gap_ticks <= wr_data;
        CFG_ERASE_TICKS: regs.erase_cycle_ticks <= wr_data;
        CFG_BULK_TICKS:  regs.bulk_erase_ticks  <= wr_data;
        default:         regs.phase_ticks       <= regs.phase_ticks;
      endcase
    end
  end

endmodule

FILE: hdl/icsp_seq.sv
// Pin sequencer: sequencer state registers and the one-tick step logic.
// Depends on icsp_pkg for phases, step tables and item structs.
module icsp_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  icsp_pkg::in_item_t   item,
  input  icsp_pkg::cfg_regs_t  cfg,
  output icsp_pkg::out_item_t  result
);
  import icsp_pkg::*;

  logic                 clock_level, clock_level_next;
  logic                 data_level, data_level_next;
  logic                 drive_enable, drive_enable_next;
  logic [15:0]          shift_word, shift_word_next;
  logic [4:0]           bit_count, bit_count_next;
  phase_t               phase, phase_next;
  logic [WAIT_BITS-1:0] wait_count, wait_count_next;
  logic [4:0]           sequence_step, sequence_step_next;
  logic [3:0]           current_operation, current_operation_next;
  logic [13:0]          held_value, held_value_next;

  // One tick: optional start, one segment when the wait has run out, countdown.
  always_comb begin
    logic   busy;
    logic   active;
    logic   rej;
    logic   rvalid;
    logic [13:0] rvalue;
    logic   advance;
    enter_t ent;

    clock_level_next       = clock_level;
    data_level_next        = data_level;
    drive_enable_next      = drive_enable;
    shift_word_next        = shift_word;
    bit_count_next         = bit_count;
    phase_next             = phase;
    wait_count_next        = wait_count;
    sequence_step_next     = sequence_step;
    current_operation_next = current_operation;
    held_value_next        = held_value;
    rej     = 1'b0;
    rvalid  = 1'b0;
    rvalue  = 14'h0000;
    advance = 1'b0;
    ent     = '0;

    busy   = (phase != PH_IDLE) || (wait_count != '0);
    active = busy;

    // Start a new operation when idle.
    if (busy) begin
      rej = (item.action != ACT_NONE);
    end else if ((item.action >= ACT_LOAD_CONFIG) && (item.action <= ACT_ERASE_PROT)) begin
      current_operation_next = item.action;
      held_value_next = (item.action >= ACT_ERASE_PROG) ? WORD_MASK : item.write_value;
      sequence_step_next = 5'd0;
      ent = enter_step(item.action, 5'd0, held_value_next);
      phase_next     = ent.phase;
      bit_count_next = 5'd0;
      if (ent.load_shift) shift_word_next = ent.shift;
      active = 1'b1;
    end

    // Pin action of the current segment.
    if (active && (wait_count_next == '0)) begin
      case (phase_next)
        PH_CMD_LEAD: begin
          wait_count_next = wait_len(cfg.phase_ticks);
          phase_next      = PH_CMD_HI;
        end
        PH_CMD_HI, PH_WR_HI: begin
          clock_level_next = 1'b1;
          data_level_next  = shift_word_next[bit_count_next[3:0]];
          wait_count_next  = wait_len(cfg.phase_ticks);
          phase_next = (phase_next == PH_CMD_HI) ? PH_CMD_LO : PH_WR_LO;
        end
        PH_CMD_LO: begin
          clock_level_next = 1'b0;
          wait_count_next  = wait_len(cfg.phase_ticks);
          bit_count_next   = 5'(bit_count_next + 5'd1);
          phase_next = (bit_count_next >= CMD_BITS) ? PH_CMD_TAIL : PH_CMD_HI;
        end
        PH_WR_LO: begin
          clock_level_next = 1'b0;
          wait_count_next  = wait_len(cfg.phase_ticks);
          bit_count_next   = 5'(bit_count_next + 5'd1);
          phase_next = (bit_count_next >= FRAME_BITS) ? PH_WR_TAIL : PH_WR_HI;
        end
        PH_CMD_TAIL: begin
          data_level_next = 1'b0;
          wait_count_next = wait_len(cfg.command_gap_ticks);
          advance = 1'b1;
        end
        PH_WR_TAIL: begin
          data_level_next = 1'b1;
          wait_count_next = wait_len(cfg.command_gap_ticks);
          advance = 1'b1;
        end
        PH_RD_LEAD: begin
          data_level_next = 1'b1;
          wait_count_next = wait_len(cfg.phase_ticks);
          phase_next      = PH_RD_REL;
        end
        PH_RD_REL: begin
          drive_enable_next = 1'b0;
          wait_count_next   = wait_len(cfg.phase_ticks);
          bit_count_next    = 5'd0;
          shift_word_next   = 16'h0000;
          phase_next        = PH_RD_HI;
        end
        PH_RD_HI: begin
          clock_level_next = 1'b1;
          wait_count_next  = wait_len(cfg.phase_ticks);
          phase_next       = PH_RD_LO;
        end
        PH_RD_LO: begin
          shift_word_next  = {item.data_pin_in, shift_word_next[15:1]};
          clock_level_next = 1'b0;
          wait_count_next  = wait_len(cfg.phase_ticks);
          bit_count_next   = 5'(bit_count_next + 5'd1);
          phase_next = (bit_count_next >= FRAME_BITS) ? PH_RD_TAIL : PH_RD_HI;
        end
        PH_RD_TAIL: begin
          drive_enable_next = 1'b1;
          wait_count_next   = wait_len(cfg.command_gap_ticks);
          advance = 1'b1;
        end
        PH_LONG_E: begin
          wait_count_next = wait_len(cfg.erase_cycle_ticks);
          advance = 1'b1;
        end
        PH_LONG_B: begin
          wait_count_next = wait_len(cfg.bulk_erase_ticks);
          advance = 1'b1;
        end
        default: begin
          phase_next      = PH_IDLE;
          wait_count_next = WAIT_BITS'(1);
        end
      endcase

      // Move on to the next step of the operation.
      if (advance) begin
        if (sequence_step_next < STEP_MAX) begin
          sequence_step_next = 5'(sequence_step_next + 5'd1);
        end
        ent = enter_step(current_operation_next, sequence_step_next, held_value_next);
        phase_next     = ent.phase;
        bit_count_next = 5'd0;
        if (ent.load_shift) shift_word_next = ent.shift;
      end
    end

    // Countdown and read completion.
    if (active) begin
      if (wait_count_next != '0) wait_count_next = wait_count_next - WAIT_BITS'(1);
      if ((phase_next == PH_IDLE) && (wait_count_next == '0)) begin
        if (current_operation_next == ACT_READ_PROG) begin
          rvalid = 1'b1;
          rvalue = shift_word_next[14:1];
        end else if (current_operation_next == ACT_READ_DATA) begin
          rvalid = 1'b1;
          rvalue = {6'h00, shift_word_next[8:1]};
        end
      end
    end

    result.clock_pin  = clock_level_next;
    result.data_pin   = data_level_next;
    result.data_drive = drive_enable_next;
    result.busy_res   = (phase_next != PH_IDLE) || (wait_count_next != '0);
    result.rejected   = rej;
    result.read_valid = rvalid;
    result.read_value = rvalue;
  end

  // Sequencer state advances once per tick taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_level       <= 1'b0;
      data_level        <= 1'b0;
      drive_enable      <= 1'b1;
      shift_word        <= 16'h0000;
      bit_count         <= 5'd0;
      phase             <= PH_IDLE;
      wait_count        <= '0;
      sequence_step     <= 5'd0;
      current_operation <= ACT_NONE;
      held_value        <= 14'h0000;
    end else if (step_en) begin
      clock_level       <= clock_level_next;
      data_level        <= data_level_next;
      drive_enable      <= drive_enable_next;
      shift_word        <= shift_word_next;
      bit_count         <= bit_count_next;
      phase             <= phase_next;
      wait_count        <= wait_count_next;
      sequence_step     <= sequence_step_next;
      current_operation <= current_operation_next;
      held_value        <= held_value_next;
    end
  end

endmodule

FILE: hdl/icsp_serial_programming_master.sv
// A request is taken into the input register and its result is offered from the result register.
// Throughput: one tick request per cycle; the sequencer step is one pass of logic
// between the input register and the result register. A result the receiver
// holds back stalls the sequencer and the input register until it is taken.
// Reset: sequencer idle, clock and data pins low, data pin driven, timing
// registers at 10 / 100 / 400000 / 1000000 ticks; no reset sweep is needed.
module icsp_serial_programming_master (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  icsp_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output icsp_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [icsp_pkg::CFG_BITS-1:0] cfg_data
);
  import icsp_pkg::*;

  logic       in_full;
  in_item_t   in_q;
  logic       advance;
  cfg_regs_t  cfg_regs;
  out_item_t  step_result;

  // The pipeline moves whenever the result register is free or being drained.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  icsp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg_regs)
  );

  icsp_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (in_full && advance),
    .item    (in_q),
    .cfg     (cfg_regs),
    .result  (step_result)
  );

  // Input and result registers with their valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) in_full <= in_valid;
      if (advance) out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_q <= in_data;
    if (advance && in_full) out_data <= step_result;
  end

endmodule

FILE: verif/tb_icsp_serial_programming_master.sv
// Self-checking testbench for the tick-driven serial programming master.
// Needs icsp_pkg and icsp_serial_programming_master; a queued driver, a clocked
// monitor and a cycle-exact predictor of the pin sequencer check every result.
`timescale 1ns / 100ps

module tb_icsp_serial_programming_master;
  import icsp_pkg::*;

  // Levels for the target data pin during filler ticks.
  localparam int PIN_RANDOM = 0;
  localparam int PIN_HIGH   = 1;
  localparam int PIN_LOW    = 2;

  // Action codes above the operation range.
  localparam logic [3:0] ACT_SPARE_LO = 4'd14;
  localparam logic [3:0] ACT_SPARE_HI = 4'd15;

  localparam logic [CFG_BITS-1:0] TICKS_MAX = {CFG_BITS{1'b1}};
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    in_item_t  tick;
    out_item_t pins;
  } tick_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = CFG_PHASE_TICKS;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  // Ticks waiting to be driven, each with the pin state it must produce.
  tick_request_t tick_q[$];
  // Pin states owed by the block for requests it has accepted.
  out_item_t     pin_result_q[$];

  logic in_fire      = 1'b0;
  int   result_count = 0;
  int   fault_count  = 0;
  int   queued_count = 0;
  int   sender_idle_pct   = 34;
  int   receiver_idle_pct = 46;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic seq_busy  = 1'b0;

  // Predicted timing registers and sequencer state.
  logic [CFG_BITS-1:0]  t_phase = 24'd10;
  logic [CFG_BITS-1:0]  t_gap   = 24'd100;
  logic [CFG_BITS-1:0]  t_erase = 24'd400000;
  logic [CFG_BITS-1:0]  t_bulk  = 24'd1000000;
  logic                 clk_lvl  = 1'b0;
  logic                 dat_lvl  = 1'b0;
  logic                 drv_en   = 1'b1;
  logic [15:0]          shreg    = '0;
  logic [4:0]           bit_idx  = '0;
  phase_t               ph       = PH_IDLE;
  logic [WAIT_BITS-1:0] wcnt     = '0;
  logic [4:0]           step_idx = '0;
  logic [3:0]           cur_op   = ACT_NONE;
  logic [13:0]          held     = '0;

  icsp_serial_programming_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A timing register of zero still waits one tick.
  function automatic logic [WAIT_BITS-1:0] nonzero_wait(logic [CFG_BITS-1:0] r);
    return (r == '0) ? WAIT_BITS'(1) : r;
  endfunction

  // Command of a primitive operation.
  function automatic logic [5:0] primitive_cmd(logic [3:0] op);
    case (op)
      ACT_LOAD_CONFIG: return CMD_LOAD_CONFIG;
      ACT_LOAD_PROG:   return CMD_LOAD_PROG;
      ACT_READ_PROG:   return CMD_READ_PROG;
      ACT_INC_ADDR:    return CMD_INC_ADDR;
      ACT_BEGIN_EP:    return CMD_BEGIN_EP;
      ACT_BEGIN_PROG:  return CMD_BEGIN_PROG;
      ACT_LOAD_DATA:   return CMD_LOAD_DATA;
      ACT_READ_DATA:   return CMD_READ_DATA;
      ACT_BULK_SETUP1: return CMD_BULK_SETUP1;
      default:         return CMD_BULK_SETUP2;
    endcase
  endfunction

  // Step schedule of every operation; anything past the last step ends it.
  function automatic seq_entry_t op_schedule(logic [3:0] op, logic [4:0] idx);
    seq_entry_t s;
    s.kind = K_END;
    s.cmd  = '0;
    if (op >= ACT_LOAD_CONFIG && op <= ACT_BULK_SETUP2) begin
      if (idx == 5'd0) begin
        s.kind = K_CMD;
        s.cmd  = primitive_cmd(op);
      end else if (idx == 5'd1) begin
        case (op)
          ACT_LOAD_CONFIG, ACT_LOAD_PROG, ACT_LOAD_DATA: s.kind = K_WR;
          ACT_READ_PROG, ACT_READ_DATA:                  s.kind = K_RD;
          ACT_BEGIN_EP:                                  s.kind = K_WE;
          default:                                       s.kind = K_END;
        endcase
      end
    end else if (op == ACT_ERASE_PROG || op == ACT_ERASE_DATA) begin
      s.kind = K_CMD;
      case (idx)
        5'd0: s.cmd = (op == ACT_ERASE_DATA) ? CMD_LOAD_DATA : CMD_LOAD_PROG;
        5'd1: s.kind = K_WR;
        5'd2, 5'd7: s.cmd = CMD_BULK_SETUP1;
        5'd3, 5'd8: s.cmd = CMD_BULK_SETUP2;
        5'd4: s.cmd = CMD_BEGIN_EP;
        5'd5: s.kind = K_WE;
        5'd6: s.kind = K_WB;
        default: s.kind = K_END;
      endcase
    end else if (op == ACT_ERASE_PROT) begin
      s.kind = K_CMD;
      case (idx)
        5'd0: s.cmd = CMD_LOAD_CONFIG;
        5'd1: s.kind = K_WR;
        5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8: s.cmd = CMD_INC_ADDR;
        5'd9, 5'd14: s.cmd = CMD_BULK_SETUP1;
        5'd10, 5'd15: s.cmd = CMD_BULK_SETUP2;
        5'd11: s.cmd = CMD_BEGIN_EP;
        5'd12: s.kind = K_WE;
        5'd13: s.kind = K_WB;
        default: s.kind = K_END;
      endcase
    end
    return s;
  endfunction

  // Set up the first segment of the current step.
  function automatic void load_step();
    seq_entry_t s;
    s = op_schedule(cur_op, step_idx);
    bit_idx = '0;
    case (s.kind)
      K_CMD: begin
        shreg = {10'h000, s.cmd};
        ph    = PH_CMD_LEAD;
      end
      K_WR: begin
        shreg = {1'b0, held, 1'b0};
        ph    = PH_WR_HI;
      end
      K_RD:    ph = PH_RD_LEAD;
      K_WE:    ph = PH_LONG_E;
      K_WB:    ph = PH_LONG_B;
      default: ph = PH_IDLE;
    endcase
  endfunction

  function automatic void next_step();
    if (step_idx < STEP_MAX) step_idx++;
    load_step();
  endfunction

  // One pin action of the sequencer, followed by its wait.
  function automatic void run_segment(logic pin);
    case (ph)
      PH_CMD_LEAD: begin
        wcnt = nonzero_wait(t_phase);
        ph   = PH_CMD_HI;
      end
      PH_CMD_HI, PH_WR_HI: begin
        clk_lvl = 1'b1;
        dat_lvl = shreg[bit_idx[3:0]];
        wcnt    = nonzero_wait(t_phase);
        ph      = (ph == PH_CMD_HI) ? PH_CMD_LO : PH_WR_LO;
      end
      PH_CMD_LO: begin
        clk_lvl = 1'b0;
        wcnt    = nonzero_wait(t_phase);
        bit_idx++;
        ph      = (bit_idx >= CMD_BITS) ? PH_CMD_TAIL : PH_CMD_HI;
      end
      PH_WR_LO: begin
        clk_lvl = 1'b0;
        wcnt    = nonzero_wait(t_phase);
        bit_idx++;
        ph      = (bit_idx >= FRAME_BITS) ? PH_WR_TAIL : PH_WR_HI;
      end
      PH_CMD_TAIL: begin
        dat_lvl = 1'b0;
        wcnt    = nonzero_wait(t_gap);
        next_step();
      end
      PH_WR_TAIL: begin
        dat_lvl = 1'b1;
        wcnt    = nonzero_wait(t_gap);
        next_step();
      end
      PH_RD_LEAD: begin
        dat_lvl = 1'b1;
        wcnt    = nonzero_wait(t_phase);
        ph      = PH_RD_REL;
      end
      PH_RD_REL: begin
        drv_en  = 1'b0;
        wcnt    = nonzero_wait(t_phase);
        bit_idx = '0;
        shreg   = '0;
        ph      = PH_RD_HI;
      end
      PH_RD_HI: begin
        clk_lvl = 1'b1;
        wcnt    = nonzero_wait(t_phase);
        ph      = PH_RD_LO;
      end
      PH_RD_LO: begin
        shreg   = {pin, shreg[15:1]};
        clk_lvl = 1'b0;
        wcnt    = nonzero_wait(t_phase);
        bit_idx++;
        ph      = (bit_idx >= FRAME_BITS) ? PH_RD_TAIL : PH_RD_HI;
      end
      PH_RD_TAIL: begin
        drv_en = 1'b1;
        wcnt   = nonzero_wait(t_gap);
        next_step();
      end
      PH_LONG_E: begin
        wcnt = nonzero_wait(t_erase);
        next_step();
      end
      PH_LONG_B: begin
        wcnt = nonzero_wait(t_bulk);
        next_step();
      end
      default: begin
        ph   = PH_IDLE;
        wcnt = WAIT_BITS'(1);
      end
    endcase
  endfunction

  // Advance the predicted sequencer by one tick and return its pin state.
  function automatic out_item_t sequencer_tick(in_item_t t);
    logic      busy;
    logic      active;
    out_item_t r;
    busy   = (ph != PH_IDLE) || (wcnt != '0);
    active = busy;
    r      = '0;
    if (busy) begin
      r.rejected = (t.action != ACT_NONE);
    end else if (t.action >= ACT_LOAD_CONFIG && t.action <= ACT_ERASE_PROT) begin
      cur_op   = t.action;
      held     = (t.action >= ACT_ERASE_PROG) ? WORD_MASK : t.write_value;
      step_idx = '0;
      load_step();
      active   = 1'b1;
    end
    if (active) begin
      if (wcnt == '0) run_segment(t.data_pin_in);
      if (wcnt != '0) wcnt--;
      if (ph == PH_IDLE && wcnt == '0) begin
        if (cur_op == ACT_READ_PROG) begin
          r.read_valid = 1'b1;
          r.read_value = shreg[14:1];
        end else if (cur_op == ACT_READ_DATA) begin
          r.read_valid = 1'b1;
          r.read_value = {6'h00, shreg[8:1]};
        end
      end
    end
    r.clock_pin  = clk_lvl;
    r.data_pin   = dat_lvl;
    r.data_drive = drv_en;
    r.busy_res   = (ph != PH_IDLE) || (wcnt != '0);
    return r;
  endfunction

  function automatic logic pick_pin(int mode);
    if (mode == PIN_HIGH) return 1'b1;
    if (mode == PIN_LOW) return 1'b0;
    return 1'($urandom_range(0, 1));
  endfunction

  // Queue one tick together with the pin state it is predicted to give.
  task automatic queue_tick(logic [3:0] act, logic [13:0] word, logic pin);
    tick_request_t req;
    req.tick.action      = act;
    req.tick.write_value = word;
    req.tick.data_pin_in = pin;
    req.pins             = sequencer_tick(req.tick);
    seq_busy             = req.pins.busy_res;
    tick_q.push_back(req);
    queued_count++;
  endtask

  // Filler ticks until the running operation ends; a few carry stray actions.
  task automatic finish_op(int noise_pct, int pin_mode);
    logic [3:0] act;
    while (seq_busy) begin
      act = ($urandom_range(0, 99) < noise_pct) ? 4'($urandom_range(1, 15)) : ACT_NONE;
      queue_tick(act, 14'($urandom), pick_pin(pin_mode));
    end
  endtask

  task automatic start_op(logic [3:0] act, logic [13:0] word, int noise_pct,
                          int pin_mode);
    queue_tick(act, word, pick_pin(pin_mode));
    finish_op(noise_pct, pin_mode);
  endtask

  // Block until every queued request has been answered and the pipe is empty.
  task automatic settle();
    while (tick_q.size() != 0 || pin_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PHASE_TICKS: t_phase = value;
      CFG_GAP_TICKS:   t_gap   = value;
      CFG_ERASE_TICKS: t_erase = value;
      default:         t_bulk  = value;
    endcase
  endtask

  task automatic program_timing(logic [CFG_BITS-1:0] p, logic [CFG_BITS-1:0] g,
                                logic [CFG_BITS-1:0] e, logic [CFG_BITS-1:0] b);
    write_reg(CFG_PHASE_TICKS, p);
    write_reg(CFG_GAP_TICKS, g);
    write_reg(CFG_ERASE_TICKS, e);
    write_reg(CFG_BULK_TICKS, b);
  endtask

  // Random primitive operations back to back, with idle ticks and ignored codes
  // mixed in, until about the given number of ticks has been queued.
  task automatic random_ops(int budget);
    int         stop_at;
    int         r;
    logic [3:0] act;
    stop_at = queued_count + budget;
    while (queued_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        queue_tick(ACT_NONE, 14'($urandom), pick_pin(PIN_RANDOM));
      end else if (r < 9) begin
        queue_tick(4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 14'($urandom),
                   pick_pin(PIN_RANDOM));
      end else begin
        act = 4'($urandom_range(ACT_LOAD_CONFIG, ACT_BULK_SETUP2));
        start_op(act, 14'($urandom), 3, PIN_RANDOM);
      end
    end
  endtask

  task automatic log_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  // Request driver: offers the oldest queued tick, holding it until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (tick_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      in_valid <= 1'b1;
      in_data  <= tick_q[0].tick;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result ready: random stalls, plus one long hold-off while ticks are queued.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && result_count >= 100 && tick_q.size() > 50) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Monitor: records accepted requests and checks each result against the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        pin_result_q.push_back(tick_q[0].pins);
        void'(tick_q.pop_front());
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (pin_result_q.size() == 0) begin
          log_fault($sformatf("result %0d arrived with none owed: %p", result_count,
                              out_data));
        end else begin
          want = pin_result_q.pop_front();
          if (out_data.clock_pin !== want.clock_pin ||
              out_data.data_pin !== want.data_pin ||
              out_data.data_drive !== want.data_drive ||
              out_data.busy_res !== want.busy_res ||
              out_data.rejected !== want.rejected ||
              out_data.read_valid !== want.read_valid ||
              out_data.read_value !== want.read_value) begin
            log_fault($sformatf({"result %0d: expected clk %b dat %b drv %b busy %b",
                                 " rej %b rv %b val %h, got %b %b %b %b %b %b %h"},
              result_count, want.clock_pin, want.data_pin, want.data_drive,
              want.busy_res, want.rejected, want.read_valid, want.read_value,
              out_data.clock_pin, out_data.data_pin, out_data.data_drive,
              out_data.busy_res, out_data.rejected, out_data.read_valid,
              out_data.read_value));
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset timing: a command runs at the reset half-phase, with a stray action
    // while busy, and the timing is shortened part way through it.
    queue_tick(ACT_INC_ADDR, 14'h0000, pick_pin(PIN_RANDOM));
    repeat (14) queue_tick(ACT_NONE, 14'($urandom), pick_pin(PIN_RANDOM));
    queue_tick(ACT_READ_PROG, WORD_MASK, 1'b1);
    repeat (14) queue_tick(ACT_NONE, 14'($urandom), pick_pin(PIN_RANDOM));
    program_timing(24'd1, 24'd1, 24'd2, 24'd3);
    finish_op(1, PIN_RANDOM);

    // Codes above the operation range are ignored while idle.
    queue_tick(ACT_SPARE_LO, WORD_MASK, 1'b1);
    queue_tick(ACT_SPARE_HI, 14'h0000, 1'b0);
    queue_tick(ACT_NONE, WORD_MASK, 1'b1);

    // Reads with constant pin levels, a patterned write and the longest macro.
    start_op(ACT_READ_PROG, 14'h0000, 0, PIN_HIGH);
    start_op(ACT_READ_DATA, WORD_MASK, 0, PIN_LOW);
    start_op(ACT_LOAD_DATA, 14'h2AAA, 5, PIN_RANDOM);
    start_op(ACT_ERASE_PROT, 14'h1555, 5, PIN_RANDOM);

    // A register written mid-operation applies from the next wait on.
    queue_tick(ACT_BEGIN_EP, 14'h0000, 1'b0);
    repeat (5) queue_tick(ACT_NONE, 14'($urandom), 1'b0);
    write_reg(CFG_ERASE_TICKS, 24'd6);
    finish_op(0, PIN_RANDOM);

    // Largest register values, exercised only by ticks that start no wait.
    program_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
    queue_tick(ACT_NONE, WORD_MASK, 1'b1);
    queue_tick(ACT_SPARE_LO, 14'h0000, 1'b0);
    queue_tick(ACT_SPARE_HI, WORD_MASK, 1'b1);

    // Zero registers wait one tick each.
    program_timing(24'd0, 24'd0, 24'd0, 24'd0);
    start_op(ACT_LOAD_PROG, WORD_MASK, 0, PIN_RANDOM);
    start_op(ACT_ERASE_DATA, 14'h0000, 0, PIN_RANDOM);

    // Random traffic under three timing settings and three idling patterns.
    program_timing(24'd1, 24'd1, 24'd2, 24'd3);
    random_ops(60);

    program_timing(24'd2, 24'd0, 24'd0, 24'd5);
    sender_idle_pct   = 46;
    receiver_idle_pct = 34;
    random_ops(60);

    program_timing(24'd3, 24'd7, 24'd1, 24'd0);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    random_ops(60);

    settle();
    repeat (16) @(posedge clk);
    if (pin_result_q.size() != 0) begin
      log_fault($sformatf("%0d results never arrived", pin_result_q.size()));
    end
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/icsp_pkg.sv
hdl/icsp_cfg.sv
hdl/icsp_seq.sv
hdl/icsp_serial_programming_master.sv
verif/tb_icsp_serial_programming_master.sv
